// ----- rtl/tccl_pkg.sv -----
package tccl_pkg;

	localparam int unsigned LEVEL_W = 3;
	localparam int unsigned COUNT_W = 4;
	localparam int unsigned TEMP_W = 9;
	localparam int unsigned CURRENT_W = 16;

	localparam logic [CURRENT_W-1:0] NO_LIMIT = 16'd9999;
	localparam logic [COUNT_W-1:0] DEBOUNCE_RESET = 4'd5;
	localparam logic signed [TEMP_W-1:0] CRIT_TEMP_RESET = 9'sd120;
	localparam logic [CURRENT_W-1:0] CRIT_CURRENT_RESET = 16'd1000;

	typedef enum logic [1:0] {
		REG_DEBOUNCE = 2'd0,
		REG_CRIT_TEMP = 2'd1,
		REG_CRIT_CURRENT = 2'd2
	} cfg_reg_t;

	// Current limit that applies at each level.
	function automatic logic [CURRENT_W-1:0] level_limit(input logic [LEVEL_W-1:0] lvl);
		logic [CURRENT_W-1:0] lim;
		case (lvl)
			3'd0: lim = NO_LIMIT;
			3'd1: lim = 16'd2500;
			3'd2: lim = 16'd2000;
			3'd3: lim = 16'd1500;
			default: lim = 16'd700;
		endcase
		return lim;
	endfunction

	// Temperature at or above which a level is left upward.
	function automatic logic signed [TEMP_W-1:0] trip_up(input logic [LEVEL_W-1:0] lvl);
		logic signed [TEMP_W-1:0] t;
		case (lvl)
			3'd0: t = 9'sd40;
			3'd1: t = 9'sd60;
			3'd2: t = 9'sd65;
			default: t = 9'sd70;
		endcase
		return t;
	endfunction

	// Temperature below which the level above this one is left downward.
	function automatic logic signed [TEMP_W-1:0] trip_down(input logic [LEVEL_W-1:0] lvl);
		logic signed [TEMP_W-1:0] t;
		case (lvl)
			3'd0: t = 9'sd35;
			3'd1: t = 9'sd57;
			3'd2: t = 9'sd62;
			default: t = 9'sd67;
		endcase
		return t;
	endfunction

endpackage

// ----- rtl/thermal_charge_current_limiter.sv -----
// Channel   Handshake                  Payload
// -------   -------------------------  ------------------------------------------------
// in        in_valid / in_ready        system_active, external_power, temp_celsius,
//                                      requested_ma
// out       out_valid / out_ready      limit_ma, thermal_level, granted_ma
// cfg       cfg_valid / cfg_ready      cfg_index, cfg_data
//
// Each input transaction lands in the input register. The level machine then updates its
// state and loads the result register, whose contents drive the output ports, and one
// transaction is taken every cycle while the output is not stalled.
// The rate is set by the single update of the level and debounce counters per tick.
// arst_n clears the level, both counters, all valid flags and the configuration
// registers to their reset values. cfg_ready is always high.
// A stalled output holds the result register and the input register; in_ready drops
// only when both registers are full and out_ready is low.
module thermal_charge_current_limiter import tccl_pkg::*; #(
	parameter int unsigned NUM_LEVELS = 5
) (
	input  logic                        clk,
	input  logic                        arst_n,

	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        system_active,
	input  logic                        external_power,
	input  logic signed [TEMP_W-1:0]    temp_celsius,
	input  logic [CURRENT_W-1:0]        requested_ma,

	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [CURRENT_W-1:0]        limit_ma,
	output logic [LEVEL_W-1:0]          thermal_level,
	output logic [CURRENT_W-1:0]        granted_ma,

	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [1:0]                  cfg_index,
	input  logic [CURRENT_W-1:0]        cfg_data
);

	// Highest level the machine can reach.
	localparam logic [LEVEL_W-1:0] TOP_LEVEL = LEVEL_W'(NUM_LEVELS - 1);

	// Configuration registers.
	logic [COUNT_W-1:0]          debounce_q;
	logic signed [TEMP_W-1:0]    crit_temp_q;
	logic [CURRENT_W-1:0]        crit_current_q;

	// Level machine state.
	logic [LEVEL_W-1:0]          level_q;
	logic [COUNT_W-1:0]          up_count_q;
	logic [COUNT_W-1:0]          down_count_q;

	// Input register.
	logic                        valid_s1;
	logic                        active_s1;
	logic                        ext_s1;
	logic signed [TEMP_W-1:0]    temp_s1;
	logic [CURRENT_W-1:0]        req_s1;

	// Result register.
	logic                        out_valid_q;
	logic [CURRENT_W-1:0]        limit_q;
	logic [LEVEL_W-1:0]          level_out_q;
	logic [CURRENT_W-1:0]        granted_q;

	// Next-state values computed from the registered tick.
	logic [LEVEL_W-1:0]          level_n;
	logic [COUNT_W-1:0]          up_n;
	logic [COUNT_W-1:0]          down_n;
	logic [CURRENT_W-1:0]        limit_n;
	logic [CURRENT_W-1:0]        granted_n;
	logic                        advance;

	// The tick in the input register moves on whenever the result register is free
	// or being emptied in this cycle.
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q     <= DEBOUNCE_RESET;
			crit_temp_q    <= CRIT_TEMP_RESET;
			crit_current_q <= CRIT_CURRENT_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_DEBOUNCE:     debounce_q     <= cfg_data[COUNT_W-1:0];
				REG_CRIT_TEMP:    crit_temp_q    <= cfg_data[TEMP_W-1:0];
				REG_CRIT_CURRENT: crit_current_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			active_s1 <= system_active;
			ext_s1    <= external_power;
			temp_s1   <= temp_celsius;
			req_s1    <= requested_ma;
		end
	end

	// Level machine: power checks first, then the critical threshold, then the
	// debounced trigger check followed by the release check on the updated level.
	always_comb begin
		level_n = level_q;
		up_n    = up_count_q;
		down_n  = down_count_q;
		if (!active_s1 || !ext_s1) begin
			level_n = '0;
			up_n    = '0;
			down_n  = '0;
			limit_n = NO_LIMIT;
		end else if (temp_s1 > crit_temp_q) begin
			level_n = '0;
			up_n    = '0;
			down_n  = '0;
			limit_n = crit_current_q;
		end else begin
			if (level_n < TOP_LEVEL) begin
				if (temp_s1 >= trip_up(level_n)) begin
					up_n = up_n + 1'b1;
					if (up_n >= debounce_q) begin
						level_n = level_n + 1'b1;
						up_n    = '0;
						down_n  = '0;
					end
				end else begin
					up_n = '0;
				end
			end
			if (level_n != '0) begin
				if (temp_s1 < trip_down(level_n - 1'b1)) begin
					down_n = down_n + 1'b1;
					if (down_n >= debounce_q) begin
						level_n = level_n - 1'b1;
						up_n    = '0;
						down_n  = '0;
					end
				end else begin
					down_n = '0;
				end
			end
			limit_n = level_limit(level_n);
		end
		granted_n = (req_s1 < limit_n) ? req_s1 : limit_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q      <= '0;
			up_count_q   <= '0;
			down_count_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (advance) begin
				level_q      <= level_n;
				up_count_q   <= up_n;
				down_count_q <= down_n;
				out_valid_q  <= 1'b1;
			end else if (out_ready) begin
				out_valid_q  <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			limit_q     <= limit_n;
			level_out_q <= level_n;
			granted_q   <= granted_n;
		end
	end

	assign out_valid     = out_valid_q;
	assign limit_ma      = limit_q;
	assign thermal_level = level_out_q;
	assign granted_ma    = granted_q;

`ifndef SYNTH
	// The level never climbs past the top level.
	assert property (@(posedge clk) disable iff (!arst_n) level_q <= TOP_LEVEL)
		else $error("level above top level");

	// A nonzero level always reports that level's table limit.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (thermal_level != '0) |-> limit_ma == level_limit(thermal_level))
		else $error("limit does not match level");

	// The granted current never exceeds the limit.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> granted_ma <= limit_ma)
		else $error("granted current above limit");

	// A tick without full power clears the level and lifts the limit.
	assert property (@(posedge clk) disable iff (!arst_n)
		advance && (!active_s1 || !ext_s1) |=>
			(limit_ma == NO_LIMIT) && (thermal_level == '0) && (level_q == '0))
		else $error("power loss did not clear the limiter");

	// Outside power loss and the critical threshold, the level state moves by at most one step per tick.
	assert property (@(posedge clk) disable iff (!arst_n)
		advance && active_s1 && ext_s1 && !(temp_s1 > crit_temp_q) |=>
			(level_q == $past(level_q)) || (level_q == $past(level_q) + 1'b1) ||
			(level_q == $past(level_q) - 1'b1))
		else $error("level jumped by more than one step");
`endif

endmodule
